// ----- design/imu_afp_pkg.sv -----
// Shared types and constants of the IMU angle frame parser.
// Holds the item structs, request and status codes and frame layout constants.
// No dependencies.
package imu_afp_pkg;

  localparam int YAW_ACC_WIDTH = 48;
  localparam int FILL_W        = 4;
  localparam int WORD_BYTES    = 6;
  localparam int WIDX_W        = 3;

  localparam logic [7:0]        HDR_SYNC   = 8'h55;
  localparam logic [7:0]        HDR_ANGLE  = 8'h53;
  localparam logic [FILL_W-1:0] FRAME_LEN  = 4'd11;
  localparam logic [FILL_W-1:0] LAST_POS   = 4'd10;
  localparam logic [FILL_W-1:0] WORD_FIRST = 4'd2;
  localparam logic [FILL_W-1:0] WORD_LAST  = 4'd7;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_BASE  = 2'd1,
    REQ_FLUSH = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2,
    ST_DONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [47:0] unwrapped_yaw;
    logic [31:0]        good_frames;
    logic [31:0]        bytes_seen;
    logic [31:0]        bad_frames;
  } out_item_t;

endpackage

// ----- design/imu_angle_frame_parser_unit.sv -----
// IMU angle frame parser top level: frame hunt, checksum, angle hold and yaw unwrap.
// Depends on imu_afp_pkg for item structs, codes and frame constants.
//
// Usage: each input item is either a received serial byte, a request to reset the
// yaw unwrap baseline, or a line error flush. Every accepted item yields exactly one
// result item carrying a status code plus the latest roll, pitch and yaw, the
// unwrapped yaw accumulator and the byte, good frame and checksum error counters.
// Both channels use valid and stall; an item moves when valid is high and stall low.
// The item is captured in the input register when it is accepted and its result is
// loaded into the output register when that register advances. Throughput is one
// item per cycle while the receiver does not stall; the checksum is a running 8-bit
// sum, and the yaw unwrap is one 18-bit subtract then one saturating accumulator add.
// When the receiver stalls, the output register holds its item, the input register
// holds the next one, and in_stall rises once both are occupied.
// Synchronous active-low reset empties both registers, returns the parser to the
// header hunt and clears held angles, baseline, accumulator and counters.
module imu_angle_frame_parser_unit
  import imu_afp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_ID   = 2'd1,
    PH_FILL = 2'd2
  } phase_t;

  localparam int ACC_W = YAW_ACC_WIDTH;

  logic                    s1_valid_r;
  in_item_t                s1_item_r;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  phase_t                  phase_r, phase_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [7:0]              sum_r, sum_nxt;
  logic [7:0]              frame_b_r [WORD_BYTES];
  logic signed [15:0]      roll_r, roll_nxt;
  logic signed [15:0]      pitch_r, pitch_nxt;
  logic signed [15:0]      yaw_r, yaw_nxt;
  logic signed [15:0]      base_r, base_nxt;
  logic                    bvalid_r, bvalid_nxt;
  logic signed [ACC_W-1:0] total_r, total_nxt;
  logic [31:0]             good_cnt_r, good_cnt_nxt;
  logic [31:0]             byte_cnt_r, byte_cnt_nxt;
  logic [31:0]             bad_cnt_r, bad_cnt_nxt;
  status_t                 status_nxt;

  logic                    advance, s1_fire, in_fire;
  logic                    wr_en;
  logic [WIDX_W-1:0]       wr_idx;
  logic [7:0]              b;
  logic signed [15:0]      yaw_word;
  logic signed [17:0]      delta_raw, delta;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_sat;

  assign advance  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign b        = s1_item_r.byte_in;
  assign yaw_word = {frame_b_r[5], frame_b_r[4]};

  always_comb begin
    delta_raw = 18'({{2{yaw_word[15]}}, yaw_word}) - 18'({{2{base_r[15]}}, base_r});
    if (delta_raw > 18'sd32768) begin
      delta = delta_raw - 18'sd65536;
    end else if (delta_raw < -18'sd32768) begin
      delta = delta_raw + 18'sd65536;
    end else begin
      delta = delta_raw;
    end
    acc_sum = (ACC_W+1)'(total_r) + (ACC_W+1)'(delta);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    fill_nxt     = fill_r;
    sum_nxt      = sum_r;
    roll_nxt     = roll_r;
    pitch_nxt    = pitch_r;
    yaw_nxt      = yaw_r;
    base_nxt     = base_r;
    bvalid_nxt   = bvalid_r;
    total_nxt    = total_r;
    good_cnt_nxt = good_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    bad_cnt_nxt  = bad_cnt_r;
    status_nxt   = ST_NONE;
    wr_en        = 1'b0;
    wr_idx       = WIDX_W'(fill_r - WORD_FIRST);
    if (s1_fire) begin
      case (s1_item_r.req_type)
        REQ_BYTE: begin
          byte_cnt_nxt = byte_cnt_r + 32'd1;
          case (phase_r)
            PH_SYNC: begin
              if (b == HDR_SYNC) begin
                sum_nxt   = b;
                fill_nxt  = 4'd1;
                phase_nxt = PH_ID;
              end
            end
            PH_ID: begin
              if (b == HDR_ANGLE) begin
                sum_nxt   = sum_r + b;
                fill_nxt  = 4'd2;
                phase_nxt = PH_FILL;
              end else if (b == HDR_SYNC) begin
                sum_nxt  = b;
                fill_nxt = 4'd1;
              end else begin
                phase_nxt = PH_SYNC;
                fill_nxt  = '0;
              end
            end
            default: begin
              if (fill_r == LAST_POS) begin
                phase_nxt = PH_SYNC;
                fill_nxt  = '0;
                if (sum_r != b) begin
                  bad_cnt_nxt = bad_cnt_r + 32'd1;
                  status_nxt  = ST_BAD;
                end else begin
                  roll_nxt     = {frame_b_r[1], frame_b_r[0]};
                  pitch_nxt    = {frame_b_r[3], frame_b_r[2]};
                  yaw_nxt      = yaw_word;
                  base_nxt     = yaw_word;
                  bvalid_nxt   = 1'b1;
                  total_nxt    = bvalid_r ? acc_sat : '0;
                  good_cnt_nxt = good_cnt_r + 32'd1;
                  status_nxt   = ST_GOOD;
                end
              end else if (fill_r < FRAME_LEN) begin
                wr_en    = fill_r inside {[WORD_FIRST:WORD_LAST]};
                sum_nxt  = sum_r + b;
                fill_nxt = fill_r + 4'd1;
              end else begin
                phase_nxt = PH_SYNC;
                fill_nxt  = '0;
              end
            end
          endcase
        end
        REQ_BASE: begin
          base_nxt   = yaw_r;
          total_nxt  = '0;
          bvalid_nxt = 1'b1;
          status_nxt = ST_DONE;
        end
        REQ_FLUSH: begin
          phase_nxt  = PH_SYNC;
          fill_nxt   = '0;
          status_nxt = ST_DONE;
        end
        default: begin
          status_nxt = ST_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_b_r[wr_idx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      out_item_r.status        <= status_nxt;
      out_item_r.roll_angle    <= roll_nxt;
      out_item_r.pitch_angle   <= pitch_nxt;
      out_item_r.yaw_angle     <= yaw_nxt;
      out_item_r.unwrapped_yaw <= 48'(total_nxt);
      out_item_r.good_frames   <= good_cnt_nxt;
      out_item_r.bytes_seen    <= byte_cnt_nxt;
      out_item_r.bad_frames    <= bad_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SYNC;
      fill_r      <= '0;
      sum_r       <= '0;
      roll_r      <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
      base_r      <= '0;
      bvalid_r    <= 1'b0;
      total_r     <= '0;
      good_cnt_r  <= '0;
      byte_cnt_r  <= '0;
      bad_cnt_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      phase_r    <= phase_nxt;
      fill_r     <= fill_nxt;
      sum_r      <= sum_nxt;
      roll_r     <= roll_nxt;
      pitch_r    <= pitch_nxt;
      yaw_r      <= yaw_nxt;
      base_r     <= base_nxt;
      bvalid_r   <= bvalid_nxt;
      total_r    <= total_nxt;
      good_cnt_r <= good_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      bad_cnt_r  <= bad_cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LAST_POS)
    else $error("Fill position ran past the checksum byte.");

  a_hunt_empty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SYNC |-> fill_r == '0)
    else $error("Header hunt with a nonzero fill position.");

  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && status_nxt == ST_GOOD |=> good_cnt_r == $past(good_cnt_r) + 32'd1)
    else $error("Good frame did not advance the frame counter.");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("Input stalled while a register was free.");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_item_r))
    else $error("Stalled result item changed.");
`endif

endmodule
